[hw/rtl/lcg_pkg.sv]
// ============================================================================
// Lexicographic combination generator package
// Shared widths, command and result codes, controller states and the
// command and status bundles between the controller and the datapath.
// ============================================================================
package lcg_pkg;

    // Default sizes of the table and of one combination.
    localparam int MAX_SET_DEF    = 64;
    localparam int MAX_CHOOSE_DEF = 16;

    // Fixed field widths.
    localparam int VALUE_BITS = 16;
    localparam int N_W        = 7;   // set_size register
    localparam int K_W        = 5;   // choose_count register
    localparam int IDX_W      = 6;   // entry_index
    localparam int POS_W      = 4;   // element_position
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 24;  // cmd, entry_index, entry_value
    localparam int M_DATA_W   = 24;  // element_value, element_position, padding
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_SIZE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHOOSE_COUNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_NEXT    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK       = 2'd0,
        KIND_ELEM      = 2'd1,
        KIND_EXHAUSTED = 2'd2,
        KIND_INVALID   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_ADVANCE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic  load;        // write the table entry of the accepted item
        logic  restart;     // pointers back to 1..k, flag cleared
        logic  put_result;  // place a single result into the output register
        t_kind kind;        // kind of that single result
        logic  emit_start;  // clear the element counter and pivot tracking
        logic  issue;       // read one element of the current combination
        logic  advance;     // step the pointers to the next combination
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic sizes_ok;     // n and k describe a valid enumeration
        logic exhausted;    // final combination already emitted
        logic cnt_last;     // the element counter is on the last element
        logic can_issue;    // the read stage is free for another element
        logic out_free;     // no element in flight and output slot free
    } t_dp_status;

endpackage

[hw/rtl/lcg_ram.sv]
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module lcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lcg_ctrl.sv]
// ============================================================================
// Combination generator controller
// Decodes accepted commands and sequences element reads and the pointer step.
// ============================================================================
module lcg_ctrl
    import lcg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  t_cmd       i_cmd,
    input  t_dp_status i_status,
    output logic       o_s_tready,
    output t_dp_cmd    o_dp_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE) && i_status.out_free;
    assign accept     = o_s_tready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd == CMD_NEXT) && i_status.sizes_ok
                    && !i_status.exhausted) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.can_issue && i_status.cnt_last) begin
                    n_state = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_dp_cmd = '0;
        o_dp_cmd.kind = KIND_ACK;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_LOAD: begin
                            o_dp_cmd.load       = 1'b1;
                            o_dp_cmd.put_result = 1'b1;
                        end
                        CMD_RESTART: begin
                            o_dp_cmd.restart    = 1'b1;
                            o_dp_cmd.put_result = 1'b1;
                        end
                        CMD_NEXT: begin
                            if (!i_status.sizes_ok) begin
                                o_dp_cmd.put_result = 1'b1;
                                o_dp_cmd.kind       = KIND_INVALID;
                            end else if (i_status.exhausted) begin
                                o_dp_cmd.put_result = 1'b1;
                                o_dp_cmd.kind       = KIND_EXHAUSTED;
                            end else begin
                                o_dp_cmd.emit_start = 1'b1;
                            end
                        end
                        default: begin
                            o_dp_cmd.put_result = 1'b1;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                o_dp_cmd.issue = i_status.can_issue;
            end
            ST_ADVANCE: begin
                o_dp_cmd.advance = 1'b1;
            end
            default: begin
                o_dp_cmd.kind = KIND_ACK;
            end
        endcase
    end

endmodule

[hw/rtl/lcg_dp.sv]
// ============================================================================
// Combination generator datapath
// Size registers, position pointers, value table, read stage and output slot.
// ============================================================================
module lcg_dp
    import lcg_pkg::*;
#(
    parameter int MAX_SET    = MAX_SET_DEF,
    parameter int MAX_CHOOSE = MAX_CHOOSE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [VALUE_BITS-1:0] i_entry_value,
    input  t_dp_cmd               i_dp_cmd,
    output t_dp_status            o_status,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output t_kind                 o_kind,
    output logic [VALUE_BITS-1:0] o_element_value,
    output logic [POS_W-1:0]      o_element_position,
    output logic                  o_last
);

    localparam int AW     = $clog2(MAX_SET);
    localparam int PMAX   = (MAX_SET > MAX_CHOOSE) ? MAX_SET : MAX_CHOOSE;
    localparam int PTR_W  = $clog2(PMAX + 1);
    localparam int LW     = ((PTR_W > N_W) ? PTR_W : N_W) + 1;
    localparam int CNT_W  = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
    localparam int IW     = (AW > IDX_W) ? AW : IDX_W;

    logic [N_W-1:0]   r_n;
    logic [K_W-1:0]   r_k;
    logic [PTR_W-1:0] r_ptr [MAX_CHOOSE];
    logic             r_exhausted;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pf;
    logic [CNT_W-1:0] r_pv;
    logic [PTR_W-1:0] r_pvv;

    logic             r_a_v;
    logic [POS_W-1:0] r_a_pos;
    logic             r_a_last;

    logic                  r_b_v;
    t_kind                 r_b_kind;
    logic [VALUE_BITS-1:0] r_b_val;
    logic [POS_W-1:0]      r_b_pos;
    logic                  r_b_last;

    logic                  do_restart;
    logic [PTR_W-1:0]      ptr_cur;
    logic [PTR_W-1:0]      ptr_dec;
    logic [LW-1:0]         limit;
    logic                  grows;
    logic                  b_free;
    logic                  a_move;
    logic [IW-1:0]         idx_ext;
    logic                  idx_in_range;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [CNT_W+POS_W-1:0] pos_ext;

    assign do_restart = i_cfg_we || i_dp_cmd.restart;

    // Current pointer and whether it can still grow (pivot test).
    assign ptr_cur = r_ptr[r_cnt];
    assign ptr_dec = ptr_cur - PTR_W'(1);
    assign limit   = LW'(r_n) - LW'(r_k) + LW'(r_cnt);
    assign grows   = LW'(ptr_cur) <= limit;
    assign pos_ext = (CNT_W + POS_W)'(r_cnt);

    assign idx_ext      = IW'(i_entry_index);
    assign idx_in_range = {1'b0, idx_ext} < (IW + 1)'(MAX_SET);

    assign b_free = !r_b_v || i_m_tready;
    assign a_move = r_a_v && b_free;

    assign o_status.sizes_ok  = (r_n != '0) && (r_k != '0) && (LW'(r_k) <= LW'(r_n))
                                && (LW'(r_n) <= LW'(MAX_SET))
                                && (LW'(r_k) <= LW'(MAX_CHOOSE));
    assign o_status.exhausted = r_exhausted;
    assign o_status.cnt_last  = (LW'(r_cnt) + LW'(1)) == LW'(r_k);
    assign o_status.can_issue = !r_a_v || b_free;
    assign o_status.out_free  = !r_a_v && b_free;

    lcg_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_SET)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.load && idx_in_range),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (i_entry_value),
        .i_re    (i_dp_cmd.issue),
        .i_raddr (ptr_dec[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_k <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SET_SIZE) begin
                r_n <= i_cfg_data[N_W-1:0];
            end else begin
                r_k <= i_cfg_data[K_W-1:0];
            end
        end
    end

    // Pointers and the exhausted flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_restart) begin
            for (int j = 0; j < MAX_CHOOSE; j++) begin
                r_ptr[j] <= PTR_W'(j + 1);
            end
            r_exhausted <= 1'b0;
        end else if (i_dp_cmd.advance) begin
            if (r_pf) begin
                // Pivot grows by one, everything after it follows on.
                for (int j = 0; j < MAX_CHOOSE; j++) begin
                    if ((LW'(j) >= LW'(r_pv)) && (LW'(j) < LW'(r_k))) begin
                        r_ptr[j] <= PTR_W'(LW'(r_pvv) + LW'(j) - LW'(r_pv) + LW'(1));
                    end
                end
            end else begin
                r_exhausted <= 1'b1;
            end
        end
    end

    // Element counter and rightmost growable pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pf  <= 1'b0;
        end else if (i_dp_cmd.emit_start) begin
            r_cnt <= '0;
            r_pf  <= 1'b0;
        end else if (i_dp_cmd.issue) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (grows) begin
                r_pf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.issue && grows) begin
            r_pv  <= r_cnt;
            r_pvv <= ptr_cur;
        end
    end

    // Read stage: position and last mark travel beside the table read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_dp_cmd.issue) begin
            r_a_v <= 1'b1;
        end else if (a_move) begin
            r_a_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.issue) begin
            r_a_pos  <= pos_ext[POS_W-1:0];
            r_a_last <= o_status.cnt_last;
        end
    end

    // Output slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (a_move || i_dp_cmd.put_result) begin
            r_b_v <= 1'b1;
        end else if (i_m_tready) begin
            r_b_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_kind <= KIND_ELEM;
            r_b_val  <= ram_rdata;
            r_b_pos  <= r_a_pos;
            r_b_last <= r_a_last;
        end else if (i_dp_cmd.put_result) begin
            r_b_kind <= i_dp_cmd.kind;
            r_b_val  <= '0;
            r_b_pos  <= '0;
            r_b_last <= 1'b1;
        end
    end

    assign o_m_tvalid         = r_b_v;
    assign o_kind             = r_b_kind;
    assign o_element_value    = r_b_val;
    assign o_element_position = r_b_pos;
    assign o_last             = r_b_last;

    // An element is read only while the counter lies inside the combination.
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.issue |-> (LW'(r_cnt) < LW'(r_k)))
        else $error("element read beyond the combination");

    // A stalled read stage keeps its element.
    a_read_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && !b_free) |=> (r_a_v && $stable(r_a_pos) && $stable(r_a_last)))
        else $error("read stage element lost under stall");

    // A single result never overtakes an element in flight or a waiting result.
    a_put_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.put_result |-> (!r_a_v && b_free && !i_dp_cmd.issue))
        else $error("single result placed while output path busy");

endmodule

[hw/rtl/lexicographic_combination_generator.sv]
// ============================================================================
// Lexicographic combination generator
// Walks through the k-element combinations of an n-entry value table in
// lexicographic order of positions, one table value per result.
// ============================================================================
//
//  Channel   Direction  Signals                         Content
//  --------  ---------  ------------------------------  ---------------------------------
//  command   in         s_tvalid/s_tready/s_tdata       cmd, entry_index, entry_value
//  result    out        m_tvalid/m_tready/m_tdata/      element_value, element_position,
//                       m_tuser/m_tlast                 kind in tuser, last in tlast
//  config    in         i_cfg_we/i_cfg_index/i_cfg_data set_size (0), choose_count (1)
//
// A load, restart or unused command, once taken, gives its acknowledge
// transfer from the output register in the next cycle. A next command is
// taken, then reads its k elements, one table element per cycle while the
// result side keeps taking transfers, through the single read port of the
// table RAM, and then steps the pointers. The last element drains through
// the read stage and output register while the pointers are stepped, so the
// next command is taken on the edge at which that element leaves.
// Reset is synchronous and clears the sizes, the pointers (to 1..k), the
// exhausted flag and all handshake state; the table is not cleared and holds
// whatever was last loaded. A stall on the result side holds the element in
// flight and holds off further table reads; the command side takes a new
// transfer only once the result path is empty or about to empty.
// ============================================================================
module lexicographic_combination_generator
    import lcg_pkg::*;
#(
    parameter int MAX_SET    = MAX_SET_DEF,
    parameter int MAX_CHOOSE = MAX_CHOOSE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, from bit 0: cmd [1:0], entry_index [7:2], entry_value [23:8]
    input  logic [S_DATA_W-1:0]   s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, from bit 0: element_value [15:0], element_position [19:16], zero [23:20]
    output logic [M_DATA_W-1:0]   m_tdata,
    // m_tuser, from bit 0: kind [1:0]
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    t_dp_cmd               dp_cmd;
    t_dp_status            dp_status;
    t_cmd                  cmd;
    t_kind                 kind;
    logic [VALUE_BITS-1:0] element_value;
    logic [POS_W-1:0]      element_position;

    // The command code occupies the lowest bits of the command transfer.
    assign cmd = t_cmd'(s_tdata[CMD_W-1:0]);

    lcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_cmd      (cmd),
        .i_status   (dp_status),
        .o_s_tready (s_tready),
        .o_dp_cmd   (dp_cmd)
    );

    lcg_dp #(
        .MAX_SET    (MAX_SET),
        .MAX_CHOOSE (MAX_CHOOSE)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_entry_index      (s_tdata[CMD_W+IDX_W-1:CMD_W]),
        .i_entry_value      (s_tdata[CMD_W+IDX_W+VALUE_BITS-1:CMD_W+IDX_W]),
        .i_dp_cmd           (dp_cmd),
        .o_status           (dp_status),
        .i_m_tready         (m_tready),
        .o_m_tvalid         (m_tvalid),
        .o_kind             (kind),
        .o_element_value    (element_value),
        .o_element_position (element_position),
        .o_last             (m_tlast)
    );

    // Result fields packed from the lowest bit up, padded to whole bytes.
    assign m_tdata = {{(M_DATA_W - VALUE_BITS - POS_W){1'b0}}, element_position, element_value};
    assign m_tuser = kind;

endmodule

[tb/sv/lexicographic_combination_generator_test.sv]
// ============================================================================
// Lexicographic combination generator testbench
// Drives load, restart, next and unused commands into the block, keeps its
// own copy of the value table, the position pointers, the exhausted flag and
// both size registers, and checks every result transfer against the results
// that copy predicts. Both stream sides idle at random. The sizes are changed
// only while the block is idle, and every next command on valid sizes reads
// only table entries that have already been loaded.
// ============================================================================
module lexicographic_combination_generator_test;
    import lcg_pkg::*;

    localparam int TABLE_DEPTH   = MAX_SET_DEF;
    localparam int CHOOSE_MAX    = MAX_CHOOSE_DEF;
    localparam int RANDOM_ITEMS  = 180;
    localparam int CYCLE_LIMIT   = 800_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 24;

    // One command as it travels on s_tdata, lowest bits first: cmd, entry_index,
    // entry_value.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      index;
        t_cmd                  cmd;
    } t_command;

    // One result as the block should present it.
    typedef struct packed {
        t_kind                 kind;
        logic [VALUE_BITS-1:0] value;
        logic [POS_W-1:0]      position;
        logic                  last;
    } t_combo_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // s_tdata, from bit 0: cmd, entry_index, entry_value.
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // m_tdata, from bit 0: element_value, element_position, zero padding.
    logic [M_DATA_W-1:0]   m_tdata;
    // m_tuser, from bit 0: kind.
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    lexicographic_combination_generator dut (.*);

    always #4 i_clk = ~i_clk;

    // Our own copy of the enumerator state.
    logic [VALUE_BITS-1:0] table_copy [TABLE_DEPTH];
    logic [N_W-1:0]        pointer_copy [CHOOSE_MAX];
    bit                    exhausted_copy;
    int                    set_size_copy;
    int                    choose_copy;

    // Entries that the stimulus has loaded so far, so that a next command on
    // valid sizes never reads an entry that holds nothing defined.
    bit                    entry_loaded [TABLE_DEPTH];

    t_command              command_queue [$];
    t_combo_result         combo_results_due [$];
    t_command              command_on_bus;
    t_combo_result         due_result;

    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    items_queued = 0;
    int                    command_gap = 0;
    int                    command_burst = 0;
    int                    result_stall = 0;
    int                    result_burst = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[cycle %0d] result mismatch: %s", cycle_count, what);
    endtask

    // Pointers back to 1..k and the exhausted flag cleared.
    function automatic void restart_pointers();
        for (int i = 0; i < CHOOSE_MAX; i++) pointer_copy[i] = N_W'(i + 1);
        exhausted_copy = 1'b0;
    endfunction

    // Works out the results of one accepted command and updates our copy of
    // the state, just as the block should.
    task automatic step_enumerator(input t_command c);
        t_combo_result r;
        int            p;
        int            j;
        bit            grown;
        bit            single;
        r      = '{kind: KIND_ACK, value: '0, position: '0, last: 1'b1};
        single = 1'b1;
        case (c.cmd)
            CMD_LOAD: begin
                table_copy[c.index] = c.value;
            end
            CMD_RESTART: begin
                restart_pointers();
            end
            CMD_NEXT: begin
                if (set_size_copy == 0 || choose_copy == 0 || choose_copy > set_size_copy
                        || set_size_copy > TABLE_DEPTH || choose_copy > CHOOSE_MAX) begin
                    r.kind = KIND_INVALID;
                end else if (exhausted_copy) begin
                    r.kind = KIND_EXHAUSTED;
                end else begin
                    single = 1'b0;
                    for (p = 0; p < choose_copy; p++) begin
                        r.kind     = KIND_ELEM;
                        r.value    = table_copy[pointer_copy[p] - 1];
                        r.position = p[POS_W-1:0];
                        r.last     = (p == choose_copy - 1);
                        combo_results_due.insert(combo_results_due.size(), r);
                    end
                    // The rightmost pointer with room left grows by one, and
                    // every pointer to its right follows on consecutively.
                    grown = 1'b0;
                    for (p = choose_copy - 1; p >= 0 && !grown; p--) begin
                        if (pointer_copy[p] <= set_size_copy - choose_copy + p) begin
                            pointer_copy[p] = pointer_copy[p] + 1'b1;
                            for (j = p + 1; j < choose_copy; j++)
                                pointer_copy[j] = pointer_copy[j - 1] + 1'b1;
                            grown = 1'b1;
                        end
                    end
                    if (!grown) exhausted_copy = 1'b1;
                end
            end
            default: ;
        endcase
        if (single) combo_results_due.insert(combo_results_due.size(), r);
    endtask

    // Idle lengths: mostly none or short, now and then long, with the odd
    // stretch of back-to-back transfers.
    task automatic draw_gap(inout int burst, output int gap);
        int roll;
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (burst > 0) begin
            burst--;
        end else if (roll < 8) begin
            burst = $urandom_range(8, 40);
        end else if (roll >= 88) begin
            gap = $urandom_range(4, 24);
        end else if (roll >= 45) begin
            gap = $urandom_range(1, 3);
        end
    endtask

    task automatic queue_command(input t_cmd cmd, input int index, input int value);
        t_command c;
        c.cmd   = cmd;
        c.index = index[IDX_W-1:0];
        c.value = value[VALUE_BITS-1:0];
        if (cmd == CMD_LOAD) entry_loaded[c.index] = 1'b1;
        command_queue.insert(command_queue.size(), c);
        items_queued++;
    endtask

    task automatic wait_until_drained();
        while (command_queue.size() != 0 || s_tvalid || combo_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Both size registers are written back to back while the block is idle.
    // Each write restarts the enumeration.
    task automatic write_sizes(input int n, input int k);
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_index   <= CFG_SET_SIZE;
        i_cfg_data    <= CFG_DATA_W'(n);
        set_size_copy  = n;
        restart_pointers();
        @(posedge i_clk);
        i_cfg_index   <= CFG_CHOOSE_COUNT;
        i_cfg_data    <= CFG_DATA_W'(k);
        choose_copy    = k;
        restart_pointers();
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    // Command side. The copy of the state is stepped at the edge where the
    // transfer happens; a new command, or an idle gap, follows once the bus
    // is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid    <= 1'b0;
            command_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) step_enumerator(command_on_bus);
            if (!s_tvalid || s_tready) begin
                if (command_gap > 0) begin
                    command_gap--;
                    s_tvalid <= 1'b0;
                end else if (command_queue.size() != 0) begin
                    command_on_bus = command_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {command_on_bus.value, command_on_bus.index, command_on_bus.cmd};
                    draw_gap(command_burst, command_gap);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side. Each transfer is held against the oldest expected result,
    // field by field, and may be followed by a stall of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready    <= 1'b0;
            result_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (combo_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer of kind %0d", m_tuser));
                end else begin
                    due_result = combo_results_due.pop_front();
                    if (m_tuser !== due_result.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_tuser, due_result.kind));
                    if (m_tdata[VALUE_BITS-1:0] !== due_result.value)
                        report_mismatch($sformatf("element_value %h, expected %h",
                                                  m_tdata[VALUE_BITS-1:0], due_result.value));
                    if (m_tdata[VALUE_BITS +: POS_W] !== due_result.position)
                        report_mismatch($sformatf("element_position %0d, expected %0d",
                                                  m_tdata[VALUE_BITS +: POS_W],
                                                  due_result.position));
                    if (m_tlast !== due_result.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_tlast, due_result.last));
                end
                draw_gap(result_burst, result_stall);
            end
            if (result_stall > 0) begin
                result_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lexicographic_combination_generator test failed");
            $finish;
        end
    end

    initial begin
        int     n;
        int     k;
        int     ops;
        int     roll;
        longint combos;
        set_size_copy  = 0;
        choose_copy    = 0;
        restart_pointers();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset both sizes are zero, so a next command is refused.
        // The unused command and the loads carry the extreme field values.
        queue_command(CMD_NEXT, 0, 0);
        queue_command(CMD_NOP, 63, 16'hFFFF);
        queue_command(CMD_LOAD, 63, 16'hFFFF);
        queue_command(CMD_LOAD, 0, 0);
        queue_command(CMD_RESTART, 42, 16'hA5A5);

        // More entries per combination than the set holds.
        write_sizes(3, 5);
        queue_command(CMD_LOAD, 1, $urandom_range(0, 65535));
        queue_command(CMD_LOAD, 2, $urandom_range(0, 65535));
        queue_command(CMD_NEXT, 0, 0);

        // A single combination: it runs out at once and a restart brings it back.
        write_sizes(3, 3);
        queue_command(CMD_NEXT, 0, 0);
        queue_command(CMD_NEXT, 0, 0);
        queue_command(CMD_RESTART, 0, 0);
        queue_command(CMD_NEXT, 0, 0);

        // Three combinations in order, then the exhausted report.
        write_sizes(3, 2);
        repeat (4) queue_command(CMD_NEXT, 0, 0);

        // Full set with nothing chosen, then an empty set with the most chosen.
        write_sizes(64, 0);
        queue_command(CMD_NEXT, 0, 0);
        write_sizes(0, 16);
        queue_command(CMD_NEXT, 0, 0);

        // Random part: each round picks sizes, loads any entry still missing,
        // then mostly steps through the enumeration with random content in
        // the unused fields, mixed with restarts, loads and unused commands.
        while (items_queued < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                n = 64;
                k = 16;
            end else if (roll < 12) begin
                n = 64;
                k = 1;
            end else if (roll < 16) begin
                n = 16;
                k = 16;
            end else if (roll < 20) begin
                n = 0;
                k = $urandom_range(0, 16);
            end else if (roll < 23) begin
                n = $urandom_range(0, 64);
                k = 0;
            end else if (roll < 27) begin
                n = $urandom_range(1, 15);
                k = $urandom_range(n + 1, 16);
            end else begin
                n = $urandom_range(1, 7);
                k = $urandom_range(1, n);
            end
            write_sizes(n, k);
            for (int i = 0; i < n; i++)
                if (!entry_loaded[i]) queue_command(CMD_LOAD, i, $urandom_range(0, 65535));
            if (k >= 1 && k <= n) begin
                combos = 1;
                for (int i = 0; i < k; i++) combos = combos * (n - i) / (i + 1);
                ops = (combos + 2 > 40) ? 40 : int'(combos) + 2;
            end else begin
                ops = 3;
            end
            repeat (ops) begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    queue_command(CMD_NEXT, $urandom_range(0, 63), $urandom_range(0, 65535));
                else if (roll < 88)
                    queue_command(CMD_RESTART, $urandom_range(0, 63), $urandom_range(0, 65535));
                else if (roll < 95)
                    queue_command(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 65535));
                else
                    queue_command(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 65535));
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && combo_results_due.size() == 0) begin
            $display("lexicographic_combination_generator test passed");
        end else begin
            $display("lexicographic_combination_generator test failed");
        end
        $finish;
    end

endmodule

[lexicographic_combination_generator.f]
hw/rtl/lcg_pkg.sv
hw/rtl/lcg_ram.sv
hw/rtl/lcg_ctrl.sv
hw/rtl/lcg_dp.sv
hw/rtl/lexicographic_combination_generator.sv
tb/sv/lexicographic_combination_generator_test.sv
